>>> hw/rtl/bcvs_pkg.sv
// ----------------------------------------------------------------------------
// bcvs_pkg
// Shared types and codes for the bounded control value sweep block.
// ----------------------------------------------------------------------------
package bcvs_pkg;

	localparam int NUM_LANES = 8;
	localparam int BYTE_W    = 8;
	localparam int VALUE_W   = NUM_LANES * BYTE_W;

	// command kinds
	localparam logic [2:0] KIND_ADVANCE = 3'd0;
	localparam logic [2:0] KIND_LOAD    = 3'd1;
	localparam logic [2:0] KIND_SET_MAX = 3'd2;
	localparam logic [2:0] KIND_SET_MIN = 3'd3;
	localparam logic [2:0] KIND_RESTORE = 3'd4;

	// outcome codes
	localparam logic [1:0] OUT_DONE     = 2'd0;
	localparam logic [1:0] OUT_REFUSED  = 2'd1;
	localparam logic [1:0] OUT_DISABLED = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_BYTE_COUNT  = 3'd0;
	localparam logic [2:0] REG_INITIAL     = 3'd1;
	localparam logic [2:0] REG_MAX         = 3'd2;
	localparam logic [2:0] REG_MIN         = 3'd3;
	localparam logic [2:0] REG_MAX_PRESENT = 3'd4;
	localparam logic [2:0] REG_MIN_PRESENT = 3'd5;
	localparam logic [2:0] REG_DISABLED    = 3'd6;

	typedef struct packed {
		logic [2:0]         kind;
		logic [VALUE_W-1:0] candidate_bytes;
		logic [3:0]         candidate_length;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         outcome;
		logic [VALUE_W-1:0] value_now;
		logic [3:0]         position_now;
	} res_t;

	typedef struct packed {
		logic [3:0]         byte_count;
		logic [VALUE_W-1:0] initial_bytes;
		logic [VALUE_W-1:0] max_bytes;
		logic [VALUE_W-1:0] min_bytes;
		logic               max_present;
		logic               min_present;
		logic               disabled;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] a_next;
		logic [BYTE_W-1:0] init_byte;
		logic              over;
		logic              below;
	} unit_res_t;

endpackage

>>> hw/rtl/bcvs_cfg.sv
// ----------------------------------------------------------------------------
// bcvs_cfg
// Configuration register file, written over a valid/ready channel.
// ----------------------------------------------------------------------------
module bcvs_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [bcvs_pkg::VALUE_W-1:0] cfg_data,
	output bcvs_pkg::cfg_t            regs
);

	bcvs_pkg::cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.byte_count    <= 4'd1;
			regs_q.initial_bytes <= '0;
			regs_q.max_bytes     <= '0;
			regs_q.min_bytes     <= '0;
			regs_q.max_present   <= 1'b0;
			regs_q.min_present   <= 1'b0;
			regs_q.disabled      <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bcvs_pkg::REG_BYTE_COUNT:  regs_q.byte_count    <= cfg_data[3:0];
				bcvs_pkg::REG_INITIAL:     regs_q.initial_bytes <= cfg_data;
				bcvs_pkg::REG_MAX:         regs_q.max_bytes     <= cfg_data;
				bcvs_pkg::REG_MIN:         regs_q.min_bytes     <= cfg_data;
				bcvs_pkg::REG_MAX_PRESENT: regs_q.max_present   <= cfg_data[0];
				bcvs_pkg::REG_MIN_PRESENT: regs_q.min_present   <= cfg_data[0];
				bcvs_pkg::REG_DISABLED:    regs_q.disabled      <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/bcvs_byte_unit.sv
// ----------------------------------------------------------------------------
// bcvs_byte_unit
// Shared byte unit: picks one byte lane, optionally increments it and bounds-checks it.
// ----------------------------------------------------------------------------
module bcvs_byte_unit (
	input  logic [bcvs_pkg::VALUE_W-1:0] a_word,
	input  logic [bcvs_pkg::VALUE_W-1:0] hi_word,
	input  logic [bcvs_pkg::VALUE_W-1:0] lo_word,
	input  logic [bcvs_pkg::VALUE_W-1:0] init_word,
	input  logic [2:0]                   lane,
	input  logic                         hi_present,
	input  logic                         inc,
	output bcvs_pkg::unit_res_t          res
);

	logic [bcvs_pkg::BYTE_W-1:0] a_b, hi_b, lo_b;
	logic [bcvs_pkg::BYTE_W:0]   sum;

	always_comb begin
		a_b  = a_word[lane*bcvs_pkg::BYTE_W +: bcvs_pkg::BYTE_W];
		hi_b = hi_present ? hi_word[lane*bcvs_pkg::BYTE_W +: bcvs_pkg::BYTE_W] : 8'hFF;
		lo_b = lo_word[lane*bcvs_pkg::BYTE_W +: bcvs_pkg::BYTE_W];
		// nine bits so that 255 + 1 overflows any bound
		sum  = {1'b0, a_b} + {8'd0, inc};
		res.a_next    = sum[bcvs_pkg::BYTE_W-1:0];
		res.init_byte = init_word[lane*bcvs_pkg::BYTE_W +: bcvs_pkg::BYTE_W];
		res.over      = sum > {1'b0, hi_b};
		res.below     = lo_b > a_b;
	end

endmodule

>>> hw/rtl/bounded_control_value_sweep.sv
// ----------------------------------------------------------------------------
// bounded_control_value_sweep
// Holds a control value of up to eight bytes and steps it through settings.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its result
// appears on result for exactly one cycle with done high; the receiver cannot
// stall, so capture result on every cycle that done is high. Work is done one
// byte lane per cycle by a single shared increment/compare unit. An advance
// visits every byte that wraps back to its initial value and then the byte it
// steps, and makes one more check when it runs off the end of the value; a
// load whose length matches checks each byte in use in turn, stopping early
// at the first byte out of bounds; every other request is settled when it is
// taken. done rises in the cycle after the last step, and busy falls at the
// same edge, so the next request may
// be given while a result is still on show. Configuration is taken on
// cfg_valid at any time (cfg_ready is always high) but must only change while
// no request is in flight. The sweep pointer only moves forwards and is
// cleared by reset alone.
// ----------------------------------------------------------------------------
module bounded_control_value_sweep #(
	parameter int MAX_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  bcvs_pkg::cmd_t               cmd,
	output logic                         done,
	output bcvs_pkg::res_t               result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [bcvs_pkg::VALUE_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADV  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	localparam logic [3:0] MaxCount = 4'(MAX_BYTES);

	bcvs_pkg::cfg_t              regs;
	bcvs_pkg::unit_res_t         ures;
	logic [bcvs_pkg::VALUE_W-1:0] cand_q;
	logic [1:0]                  state_q;
	logic [bcvs_pkg::VALUE_W-1:0] cur_q;
	logic [3:0]                  pos_q;
	logic [2:0]                  idx_q;
	logic [1:0]                  outcome_q;
	logic                        done_q;

	logic [3:0]                  count;
	logic [bcvs_pkg::VALUE_W-1:0] mask;
	logic [2:0]                  lane;
	logic                        adv_mode;
	logic                        accept;
	logic                        load_fail;

	bcvs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Clamp the byte count into 1..MAX_BYTES and build the in-use byte mask.
	always_comb begin
		if (regs.byte_count == 4'd0) begin
			count = 4'd1;
		end else if (regs.byte_count > MaxCount) begin
			count = MaxCount;
		end else begin
			count = regs.byte_count;
		end
		for (int i = 0; i < bcvs_pkg::NUM_LANES; i++) begin
			mask[i*bcvs_pkg::BYTE_W +: bcvs_pkg::BYTE_W] = (4'(i) < count) ? 8'hFF : 8'h00;
		end
	end

	// The shared unit looks at the pointer lane for an advance and at the
	// check lane of the candidate for a load.
	assign adv_mode = (state_q == ST_ADV);
	assign lane     = adv_mode ? pos_q[2:0] : idx_q;

	bcvs_byte_unit u_unit (
		.a_word     (adv_mode ? cur_q : cand_q),
		.hi_word    (regs.max_bytes),
		.lo_word    (regs.min_bytes),
		.init_word  (regs.initial_bytes),
		.lane       (lane),
		.hi_present (regs.max_present),
		.inc        (adv_mode),
		.res        (ures)
	);

	assign load_fail = (regs.min_present && ures.below) || (regs.max_present && ures.over);
	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;

	always_comb begin
		result.outcome      = outcome_q;
		result.value_now    = cur_q & mask;
		result.position_now = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cand_q    <= '0;
			cur_q     <= '0;
			pos_q     <= '0;
			idx_q     <= '0;
			outcome_q <= bcvs_pkg::OUT_DONE;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cand_q <= cmd.candidate_bytes;
						idx_q  <= '0;
						if (regs.disabled) begin
							outcome_q <= bcvs_pkg::OUT_DISABLED;
							done_q    <= 1'b1;
						end else begin
							case (cmd.kind)
								bcvs_pkg::KIND_ADVANCE: begin
									state_q <= ST_ADV;
								end
								bcvs_pkg::KIND_LOAD: begin
									if (cmd.candidate_length == count) begin
										state_q <= ST_LOAD;
									end else begin
										outcome_q <= bcvs_pkg::OUT_REFUSED;
										done_q    <= 1'b1;
									end
								end
								bcvs_pkg::KIND_SET_MAX: begin
									cur_q <= (cur_q & ~mask) |
										((regs.max_present ? regs.max_bytes : '1) & mask);
									outcome_q <= bcvs_pkg::OUT_DONE;
									done_q    <= 1'b1;
								end
								bcvs_pkg::KIND_SET_MIN: begin
									if (regs.min_present) begin
										cur_q     <= (cur_q & ~mask) | (regs.min_bytes & mask);
										outcome_q <= bcvs_pkg::OUT_DONE;
									end else begin
										outcome_q <= bcvs_pkg::OUT_REFUSED;
									end
									done_q <= 1'b1;
								end
								bcvs_pkg::KIND_RESTORE: begin
									cur_q     <= (cur_q & ~mask) | (regs.initial_bytes & mask);
									outcome_q <= bcvs_pkg::OUT_DONE;
									done_q    <= 1'b1;
								end
								default: begin
									outcome_q <= bcvs_pkg::OUT_REFUSED;
									done_q    <= 1'b1;
								end
							endcase
						end
					end
				end
				ST_ADV: begin
					if (pos_q >= count) begin
						// sweep exhausted
						outcome_q <= bcvs_pkg::OUT_REFUSED;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else if (ures.over) begin
						// wrap this byte back to its initial value, move on
						cur_q[lane*bcvs_pkg::BYTE_W +: bcvs_pkg::BYTE_W] <= ures.init_byte;
						pos_q <= pos_q + 4'd1;
					end else begin
						cur_q[lane*bcvs_pkg::BYTE_W +: bcvs_pkg::BYTE_W] <= ures.a_next;
						outcome_q <= bcvs_pkg::OUT_DONE;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					if (load_fail) begin
						outcome_q <= bcvs_pkg::OUT_REFUSED;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else if ({1'b0, idx_q} == count - 4'd1) begin
						cur_q     <= (cur_q & ~mask) | (cand_q & mask);
						outcome_q <= bcvs_pkg::OUT_DONE;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result is only shown once the sequencer has gone back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE)
		else $error("result strobe while sequencer busy");

	// Leaving a multi-cycle request always produces its result.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// The sweep pointer never moves backwards.
	a_pos_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> pos_q >= $past(pos_q))
		else $error("sweep pointer moved backwards");

	// The pointer never goes past the widest control value.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 4'(bcvs_pkg::NUM_LANES))
		else $error("sweep pointer out of range");

	// A disabled outcome is only given while the block is disabled.
	a_dis_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome_q == bcvs_pkg::OUT_DISABLED |-> regs.disabled)
		else $error("disabled outcome while enabled");

endmodule

>>> test/tb_bounded_control_value_sweep.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_control_value_sweep
// Self-checking bench for the bounded control value sweep block. Commands go
// in through the start/busy handshake and every result is checked, field by
// field and in order, against a predictor that keeps its own copy of the
// control value, the sweep pointer and the register settings. A short
// directed run covers the edge cases; randomised phases at several register
// settings follow, with random sender gaps except in the last phase.
// ----------------------------------------------------------------------------
module tb_bounded_control_value_sweep;
	import bcvs_pkg::*;

	// index past the last real register; the block must ignore writes to it
	localparam logic [2:0] REG_SPARE = 3'd7;
	// command kinds the block does not define
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
	localparam int unsigned MAX_SHOWN = 10;
	localparam int unsigned PHASE_ITEMS = 245;
	localparam int unsigned DISABLED_ITEMS = 60;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the settings and the sweep state, predicts the result
	// of each accepted request and checks results in arrival order.
	// ------------------------------------------------------------------------
	class sweep_scoreboard;
		cfg_t               cfg;
		logic [VALUE_W-1:0] value_reg;
		logic [3:0]         sweep_ptr;
		res_t               due_reports[$];
		int unsigned        failures;

		function new();
			cfg = '0;
			cfg.byte_count = 4'd1;
			value_reg = '0;
			sweep_ptr = '0;
			failures = 0;
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= MAX_SHOWN) begin
				$display("%0t: %s", $time, msg);
			end
		endfunction

		// out-of-range byte counts are clamped to 1..8
		function int unsigned lanes_in_use();
			if (cfg.byte_count == 0) return 1;
			if (cfg.byte_count > NUM_LANES) return NUM_LANES;
			return {28'd0, cfg.byte_count};
		endfunction

		function void note_register(logic [2:0] idx, logic [VALUE_W-1:0] data);
			case (idx)
				REG_BYTE_COUNT:  cfg.byte_count = data[3:0];
				REG_INITIAL:     cfg.initial_bytes = data;
				REG_MAX:         cfg.max_bytes = data;
				REG_MIN:         cfg.min_bytes = data;
				REG_MAX_PRESENT: cfg.max_present = data[0];
				REG_MIN_PRESENT: cfg.min_present = data[0];
				REG_DISABLED:    cfg.disabled = data[0];
				default: ;
			endcase
		endfunction

		function res_t apply_command(cmd_t c);
			res_t               r;
			int unsigned        n;
			logic [VALUE_W-1:0] keep;
			logic [VALUE_W-1:0] src;
			logic [BYTE_W:0]    nxt;
			logic [BYTE_W-1:0]  bound;
			logic               stepped;
			logic               fits;
			n = lanes_in_use();
			keep = '1;
			if (n < NUM_LANES) keep = (VALUE_W'(1) << (BYTE_W * n)) - VALUE_W'(1);
			r.outcome = OUT_DONE;
			if (cfg.disabled) begin
				r.outcome = OUT_DISABLED;
			end else begin
				case (c.kind)
					KIND_ADVANCE: begin
						// walk forward, restoring every lane that would pass its bound
						r.outcome = OUT_REFUSED;
						stepped = 1'b0;
						while (!stepped && sweep_ptr < n) begin
							nxt = {1'b0, value_reg[BYTE_W*sweep_ptr +: BYTE_W]} + 9'd1;
							bound = cfg.max_present ? cfg.max_bytes[BYTE_W*sweep_ptr +: BYTE_W]
								: 8'hff;
							if (nxt > {1'b0, bound}) begin
								value_reg[BYTE_W*sweep_ptr +: BYTE_W] =
									cfg.initial_bytes[BYTE_W*sweep_ptr +: BYTE_W];
								sweep_ptr = sweep_ptr + 4'd1;
							end else begin
								value_reg[BYTE_W*sweep_ptr +: BYTE_W] = nxt[BYTE_W-1:0];
								r.outcome = OUT_DONE;
								stepped = 1'b1;
							end
						end
					end
					KIND_LOAD: begin
						fits = (c.candidate_length == n);
						for (int i = 0; i < n; i++) begin
							if (cfg.min_present && cfg.min_bytes[BYTE_W*i +: BYTE_W] >
								c.candidate_bytes[BYTE_W*i +: BYTE_W]) fits = 1'b0;
							if (cfg.max_present && cfg.max_bytes[BYTE_W*i +: BYTE_W] <
								c.candidate_bytes[BYTE_W*i +: BYTE_W]) fits = 1'b0;
						end
						if (fits) value_reg = (value_reg & ~keep) | (c.candidate_bytes & keep);
						else r.outcome = OUT_REFUSED;
					end
					KIND_SET_MAX: begin
						src = cfg.max_present ? cfg.max_bytes : '1;
						value_reg = (value_reg & ~keep) | (src & keep);
					end
					KIND_SET_MIN: begin
						if (cfg.min_present) value_reg = (value_reg & ~keep) | (cfg.min_bytes & keep);
						else r.outcome = OUT_REFUSED;
					end
					KIND_RESTORE: begin
						value_reg = (value_reg & ~keep) | (cfg.initial_bytes & keep);
					end
					default: r.outcome = OUT_REFUSED;
				endcase
			end
			r.value_now = value_reg & keep;
			r.position_now = sweep_ptr;
			return r;
		endfunction

		function void note_command(cmd_t c);
			due_reports.push_back(apply_command(c));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_reports.size() == 0) begin
				note_failure($sformatf("result with none due: outcome %0d value %h position %0d",
					got.outcome, got.value_now, got.position_now));
				return;
			end
			want = due_reports.pop_front();
			if (got.outcome !== want.outcome)
				note_failure($sformatf("outcome: expected %0d, got %0d",
					want.outcome, got.outcome));
			if (got.value_now !== want.value_now)
				note_failure($sformatf("value_now: expected %h, got %h",
					want.value_now, got.value_now));
			if (got.position_now !== want.position_now)
				note_failure($sformatf("position_now: expected %0d, got %0d",
					want.position_now, got.position_now));
		endfunction

		function void count_leftovers();
			while (due_reports.size() != 0) begin
				note_failure("result never arrived");
				void'(due_reports.pop_front());
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block I/O. Every input starts at a known value.
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	cmd_t               cmd_in = '0;
	logic               cfg_valid = 1'b0;
	logic [2:0]         cfg_index = REG_BYTE_COUNT;
	logic [VALUE_W-1:0] cfg_data = '0;
	logic               busy;
	logic               done;
	logic               cfg_ready;
	res_t               result;

	sweep_scoreboard sb = new();
	int unsigned     idle_on = 1;

	always #6 clk = ~clk;

	bounded_control_value_sweep #(
		.MAX_BYTES(NUM_LANES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd_in),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The receiver cannot stall: take every result on the edge that ends its
	// strobe cycle. Values read here are the ones from before the edge.
	always @(posedge clk) begin
		if (done === 1'b1) begin
			sb.check_result(result);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Present one request and hold it until the block takes it. Start is left
	// high afterwards, so back-to-back requests need no extra edge; lower it
	// only when a gap is inserted.
	task automatic send(cmd_t c);
		start <= 1'b1;
		cmd_in <= c;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(c);
		if (idle_on != 0 && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Drop start and wait for every outstanding result. Every request yields
	// exactly one result, so the block is idle once the queue has emptied.
	task automatic drain();
		start <= 1'b0;
		while (sb.due_reports.size() != 0) @(posedge clk);
	endtask

	// Write one register; valid is left high for the next write.
	task automatic put_reg(logic [2:0] idx, logic [VALUE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.note_register(idx, data);
	endtask

	// Write the full register set. Narrow registers carry random upper bits,
	// which the block must discard; the spare index gets noise too.
	task automatic apply_settings(cfg_t s);
		logic [VALUE_W-1:0] junk;
		junk = {$urandom(), $urandom()};
		put_reg(REG_BYTE_COUNT, {junk[VALUE_W-1:4], s.byte_count});
		put_reg(REG_INITIAL, s.initial_bytes);
		put_reg(REG_MAX, s.max_bytes);
		put_reg(REG_MIN, s.min_bytes);
		put_reg(REG_MAX_PRESENT, {junk[VALUE_W-1:1], s.max_present});
		put_reg(REG_MIN_PRESENT, {junk[VALUE_W-2:0], s.min_present});
		put_reg(REG_SPARE, junk);
		put_reg(REG_DISABLED, {~junk[VALUE_W-1:1], s.disabled});
		cfg_valid <= 1'b0;
	endtask

	function automatic cmd_t make_cmd(logic [2:0] kind, logic [VALUE_W-1:0] bytes,
		logic [3:0] len);
		cmd_t c;
		c.kind = kind;
		c.candidate_bytes = bytes;
		c.candidate_length = len;
		return c;
	endfunction

	// Random bounds per lane: mostly min at or below max, now and then swapped so
	// that, with both bounds present and unequal, the lane refuses every load.
	function automatic cfg_t random_settings(logic [3:0] count);
		cfg_t              s;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		s = '0;
		s.byte_count = count;
		for (int i = 0; i < NUM_LANES; i++) begin
			lo = 8'($urandom_range(0, 160));
			hi = 8'($urandom_range(255, lo));
			if ($urandom_range(0, 9) == 0) begin
				s.min_bytes[BYTE_W*i +: BYTE_W] = hi;
				s.max_bytes[BYTE_W*i +: BYTE_W] = lo;
			end else begin
				s.min_bytes[BYTE_W*i +: BYTE_W] = lo;
				s.max_bytes[BYTE_W*i +: BYTE_W] = hi;
			end
			s.initial_bytes[BYTE_W*i +: BYTE_W] = 8'($urandom_range(0, 255));
		end
		s.max_present = 1'($urandom_range(0, 1));
		s.min_present = 1'($urandom_range(0, 1));
		return s;
	endfunction

	// Mostly well-formed requests: loads of the right length with every lane
	// in bounds. The rest is noise: wrong lengths, random bytes, unused kinds.
	function automatic cmd_t random_command();
		cmd_t              c;
		int unsigned       pick;
		int unsigned       n;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		c.kind = KIND_ADVANCE;
		c.candidate_bytes = {$urandom(), $urandom()};
		c.candidate_length = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		n = sb.lanes_in_use();
		if (pick < 35) begin
			c.kind = KIND_ADVANCE;
		end else if (pick < 65) begin
			c.kind = KIND_LOAD;
			if (pick < 59) begin
				c.candidate_length = 4'(n);
				for (int i = 0; i < n; i++) begin
					lo = sb.cfg.min_present ? sb.cfg.min_bytes[BYTE_W*i +: BYTE_W] : 8'h00;
					hi = sb.cfg.max_present ? sb.cfg.max_bytes[BYTE_W*i +: BYTE_W] : 8'hff;
					if (lo <= hi)
						c.candidate_bytes[BYTE_W*i +: BYTE_W] = 8'($urandom_range(hi, lo));
				end
			end
		end else if (pick < 69) begin
			c.kind = KIND_SET_MAX;
		end else if (pick < 79) begin
			c.kind = KIND_SET_MIN;
		end else if (pick < 91) begin
			c.kind = KIND_RESTORE;
		end else begin
			c.kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		cfg_t               s;
		logic [VALUE_W-1:0] v;
		int unsigned        items;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: one lane, no bounds.
		send(make_cmd(KIND_ADVANCE, '0, 4'd1));
		send(make_cmd(KIND_SET_MIN, '1, 4'd1));             // no minimum: refused
		send(make_cmd(KIND_LOAD, 64'hffff_ffff_ffff_ff80, 4'd1)); // upper lanes masked
		send(make_cmd(KIND_LOAD, '1, 4'd0));                // length mismatch
		send(make_cmd(KIND_LOAD, '0, 4'd15));               // length beyond any count
		send(make_cmd(KIND_RESTORE, '0, 4'd0));
		send(make_cmd(KIND_SET_MAX, '0, 4'd0));
		send(make_cmd(KIND_UNUSED_FIRST, '1, 4'd8));
		send(make_cmd(KIND_UNUSED_LAST, '1, 4'd8));
		send(make_cmd(KIND_ADVANCE, '0, 4'd0));             // lane wraps, sweep exhausted
		send(make_cmd(KIND_ADVANCE, '0, 4'd0));             // still exhausted
		drain();

		// Directed, all eight lanes with both bounds.
		s = '0;
		s.byte_count = 4'd8;
		s.initial_bytes = 64'h0807_0605_0403_0201;
		s.max_bytes = 64'hf0e0_d0c0_b0a0_9080;
		s.min_bytes = 64'h1010_1010_1010_1010;
		s.max_present = 1'b1;
		s.min_present = 1'b1;
		apply_settings(s);
		send(make_cmd(KIND_LOAD, s.min_bytes, 4'd8));       // exactly at the minimum
		send(make_cmd(KIND_LOAD, s.max_bytes, 4'd8));       // exactly at the maximum
		v = s.min_bytes;
		v[3*BYTE_W +: BYTE_W] = 8'h0f;
		send(make_cmd(KIND_LOAD, v, 4'd8));                 // one lane below its minimum
		v = s.max_bytes;
		v[5*BYTE_W +: BYTE_W] = 8'hd1;
		send(make_cmd(KIND_LOAD, v, 4'd8));                 // one lane above its maximum
		send(make_cmd(KIND_LOAD, s.min_bytes, 4'd7));
		send(make_cmd(KIND_SET_MIN, '0, 4'd0));
		send(make_cmd(KIND_ADVANCE, '0, 4'd0));
		send(make_cmd(KIND_SET_MAX, '0, 4'd0));
		v = s.max_bytes;
		v[2*BYTE_W +: BYTE_W] = 8'h20;
		send(make_cmd(KIND_LOAD, v, 4'd8));
		send(make_cmd(KIND_ADVANCE, '0, 4'd0));             // wrap one lane, step the next
		send(make_cmd(KIND_RESTORE, '0, 4'd0));
		drain();

		// Park a lane above its bound while the upper bound is off, then advance on it.
		s.max_present = 1'b0;
		apply_settings(s);
		v = s.min_bytes;
		v[2*BYTE_W +: BYTE_W] = 8'hfe;
		send(make_cmd(KIND_LOAD, v, 4'd8));
		drain();
		s.max_present = 1'b1;
		apply_settings(s);
		send(make_cmd(KIND_ADVANCE, '0, 4'd0));
		drain();
		s.disabled = 1'b1;
		apply_settings(s);
		send(make_cmd(KIND_ADVANCE, '0, 4'd0));
		send(make_cmd(KIND_SET_MAX, '0, 4'd0));
		drain();

		// Random phases. Hold the extreme settings (tight bounds, disabled) for
		// the later phases; tight bounds exhaust the sweep pointer quickly.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: s = random_settings(4'd8);
				1: s = random_settings(4'($urandom_range(1, 8)));
				2: begin
					s = random_settings(4'd1);
					s.max_bytes = '1;
					s.min_bytes = '0;
					s.max_present = 1'b1;
					s.min_present = 1'b1;
				end
				3: s = random_settings($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15)));
				4: begin
					s = random_settings(4'd8);
					s.disabled = 1'b1;
				end
				5: begin
					s = random_settings(4'd8);
					s.max_bytes = '0;
					s.min_bytes = '1;
					s.max_present = 1'b1;
					s.min_present = 1'b1;
				end
				default: s = random_settings(4'($urandom_range(1, 8)));
			endcase
			apply_settings(s);
			items = (phase == 4) ? DISABLED_ITEMS : PHASE_ITEMS;
			idle_on = 0;
			for (int k = 0; k < items; k++) begin
				// switch gaps on and off in stretches; none in the final phase
				if (phase < 6 && k % 32 == 0) idle_on = ($urandom_range(0, 3) != 0) ? 1 : 0;
				send(random_command());
			end
			drain();
		end

		// Let any stray strobe show up before the leftovers are counted.
		repeat (NUM_LANES + 4) @(posedge clk);
		sb.count_leftovers();
		if (sb.failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
